// ===== rtl/dqv_pkg.sv =====
// ----------------------------------------------------------------------------
// dqv_pkg: shared types and constants for the dotted-quad validator
// Holds the character class codes, the queue item layout and the limits
// that decide whether a string is a valid IPv4 address.
// ----------------------------------------------------------------------------
package dqv_pkg;

	// Class of one character as seen by the front end.
	typedef enum logic [1:0] {
		CLS_DIGIT = 2'd0,
		CLS_DOT   = 2'd1,
		CLS_BAD   = 2'd2
	} char_class_t;

	// One classified character as it travels through the queue.
	typedef struct packed {
		char_class_t cls;
		logic [3:0]  digit;
		logic        last;
	} dqv_item_t;

	// Character codes.
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_NINE = 8'h39;
	localparam logic [7:0] CHAR_DOT  = 8'h2E;

	// Length limits; the count saturates one past the longest legal string.
	localparam logic [4:0] MIN_LEN = 5'd7;
	localparam logic [4:0] MAX_LEN = 5'd15;
	localparam logic [4:0] LEN_SAT = 5'd16;

	// Dot count limits.
	localparam logic [2:0] DOTS_NEEDED = 3'd3;
	localparam logic [2:0] DOT_SAT     = 3'd4;

	// Field value limits; the saturated value stands for anything above the max.
	localparam logic [8:0] OCTET_MAX = 9'd255;
	localparam logic [8:0] OCTET_SAT = 9'd256;

endpackage

// ===== rtl/dqv_front.sv =====
// ----------------------------------------------------------------------------
// dqv_front: input handshake and character classifier
// Accepts one character per transfer, sorts it into digit, dot or bad
// character and pushes the classified item into the queue.
// ----------------------------------------------------------------------------
module dqv_front (
	input  logic             char_valid,
	output logic             char_ready,
	input  logic [7:0]       char_code,
	input  logic             is_last,
	input  logic             queue_full,
	output logic             push,
	output dqv_pkg::dqv_item_t push_item
);

	// A transfer happens whenever a character is valid and the queue has room.
	assign char_ready = !queue_full;
	assign push       = char_valid && !queue_full;

	// Classify the character and extract its digit value.
	always_comb begin
		push_item.last  = is_last;
		push_item.digit = 4'd0;
		if (char_code inside {[dqv_pkg::CHAR_ZERO:dqv_pkg::CHAR_NINE]}) begin
			push_item.cls   = dqv_pkg::CLS_DIGIT;
			push_item.digit = 4'(char_code - dqv_pkg::CHAR_ZERO);
		end else if (char_code == dqv_pkg::CHAR_DOT) begin
			push_item.cls = dqv_pkg::CLS_DOT;
		end else begin
			push_item.cls = dqv_pkg::CLS_BAD;
		end
	end

endmodule

// ===== rtl/dqv_queue.sv =====
// ----------------------------------------------------------------------------
// dqv_queue: short queue between front and back
// A small circular buffer of classified characters so that each side can
// stall without holding up the other.
// ----------------------------------------------------------------------------
module dqv_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  dqv_pkg::dqv_item_t push_item,
	output logic               full,
	input  logic               pop,
	output logic               not_empty,
	output dqv_pkg::dqv_item_t head_item
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	dqv_pkg::dqv_item_t slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign head_item = slot_q[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/dqv_back.sv =====
// ----------------------------------------------------------------------------
// dqv_back: string state and verdict
// Consumes classified characters, tracks length, dots and the current field,
// and on the last character loads the verdict into the output register.
// ----------------------------------------------------------------------------
module dqv_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  dqv_pkg::dqv_item_t item,
	output logic               pop,
	output logic               verdict_valid,
	input  logic               verdict_ready,
	output logic               address_valid
);

	logic [4:0]  char_count_q;
	logic [2:0]  dot_count_q;
	logic [8:0]  octet_value_q;
	logic        octet_has_digit_q;
	logic        seen_bad_q;
	logic        out_valid_q;
	logic        out_data_q;

	logic [4:0]  cnt_n;
	logic [2:0]  dots_n;
	logic [8:0]  oct_n;
	logic        has_n;
	logic        bad_n;
	logic [11:0] acc;
	logic        verdict;

	// Take an item unless it is a last character and the verdict slot is busy.
	assign pop = item_valid && (!item.last || !out_valid_q || verdict_ready);

	assign verdict_valid = out_valid_q;
	assign address_valid = out_data_q;

	// Field accumulator: value times ten plus the new digit.
	assign acc = 12'(octet_value_q) * 12'd10 + 12'(item.digit);

	// State update for one character.
	always_comb begin
		cnt_n  = (char_count_q < dqv_pkg::LEN_SAT) ? char_count_q + 5'd1 : char_count_q;
		dots_n = dot_count_q;
		oct_n  = octet_value_q;
		has_n  = octet_has_digit_q;
		bad_n  = seen_bad_q;
		case (item.cls)
			dqv_pkg::CLS_DIGIT: begin
				oct_n = (acc > 12'(dqv_pkg::OCTET_MAX)) ? dqv_pkg::OCTET_SAT : acc[8:0];
				has_n = 1'b1;
			end
			dqv_pkg::CLS_DOT: begin
				bad_n  = seen_bad_q || !octet_has_digit_q
				         || (octet_value_q > dqv_pkg::OCTET_MAX);
				oct_n  = '0;
				has_n  = 1'b0;
				dots_n = (dot_count_q < dqv_pkg::DOT_SAT) ? dot_count_q + 3'd1 : dot_count_q;
			end
			default: begin
				bad_n = 1'b1;
			end
		endcase
		// Closing the final field and checking the totals.
		verdict = !bad_n && has_n && (oct_n <= dqv_pkg::OCTET_MAX)
		          && (cnt_n >= dqv_pkg::MIN_LEN) && (cnt_n <= dqv_pkg::MAX_LEN)
		          && (dots_n == dqv_pkg::DOTS_NEEDED);
	end

	// String state; cleared after each verdict.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q      <= '0;
			dot_count_q       <= '0;
			octet_value_q     <= '0;
			octet_has_digit_q <= 1'b0;
			seen_bad_q        <= 1'b0;
		end else if (pop) begin
			if (item.last) begin
				char_count_q      <= '0;
				dot_count_q       <= '0;
				octet_value_q     <= '0;
				octet_has_digit_q <= 1'b0;
				seen_bad_q        <= 1'b0;
			end else begin
				char_count_q      <= cnt_n;
				dot_count_q       <= dots_n;
				octet_value_q     <= oct_n;
				octet_has_digit_q <= has_n;
				seen_bad_q        <= bad_n;
			end
		end
	end

	// Output register: loaded on a last character, freed by a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && item.last) begin
			out_valid_q <= 1'b1;
		end else if (verdict_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && item.last) begin
			out_data_q <= verdict;
		end
	end

`ifndef ASSERT_OFF
	assert property (@(posedge clk) disable iff (!arst_n)
		char_count_q <= dqv_pkg::LEN_SAT)
		else $error("character count above saturation");

	assert property (@(posedge clk) disable iff (!arst_n)
		dot_count_q <= dqv_pkg::DOT_SAT)
		else $error("dot count above saturation");

	assert property (@(posedge clk) disable iff (!arst_n)
		octet_value_q <= dqv_pkg::OCTET_SAT)
		else $error("field value above saturation");

	assert property (@(posedge clk) disable iff (!arst_n)
		!octet_has_digit_q |-> octet_value_q == '0)
		else $error("field value without a digit");

	assert property (@(posedge clk) disable iff (!arst_n)
		pop && item.last |=> char_count_q == '0 && verdict_valid)
		else $error("state not cleared or verdict missing after last character");
`endif

endmodule

// ===== rtl/ipv4_dotted_quad_validator.sv =====
// A transferred character is written into the queue, then popped by the back
// end; popping a last character loads its verdict into the output register.
// Throughput: one character per cycle while the queue is not full.
// The queue lets input continue while a verdict waits to be taken.
// Reset clears the queue, the string state and the pending verdict.
// ----------------------------------------------------------------------------
// ipv4_dotted_quad_validator: dotted-quad IPv4 address checker
// Reads an address string one character per transfer and returns one
// verdict per string, with a classifier front end and a state back end.
// ----------------------------------------------------------------------------
module ipv4_dotted_quad_validator #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       char_valid,
	output logic       char_ready,
	input  logic [7:0] char_code,
	input  logic       is_last,
	output logic       verdict_valid,
	input  logic       verdict_ready,
	output logic       address_valid
);

	logic               push;
	logic               queue_full;
	logic               queue_not_empty;
	logic               pop;
	dqv_pkg::dqv_item_t push_item;
	dqv_pkg::dqv_item_t head_item;

	// Classifier front end.
	dqv_front u_front (
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_code  (char_code),
		.is_last    (is_last),
		.queue_full (queue_full),
		.push       (push),
		.push_item  (push_item)
	);

	// Decoupling queue.
	dqv_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (queue_full),
		.pop       (pop),
		.not_empty (queue_not_empty),
		.head_item (head_item)
	);

	// State and verdict back end.
	dqv_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (queue_not_empty),
		.item          (head_item),
		.pop           (pop),
		.verdict_valid (verdict_valid),
		.verdict_ready (verdict_ready),
		.address_valid (address_valid)
	);

endmodule
